// ===== rtl/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg: shared types and constants for the contiguous page allocator
// Action and status codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int unsigned MAX_PAGES_DEF = 1024;
    localparam int unsigned PID_WIDTH_DEF = 8;
    localparam int unsigned ACT_W         = 2;
    localparam int unsigned PID_IN_W      = 8;
    localparam int unsigned CNT_W         = 11;
    localparam int unsigned PNUM_W        = 10;
    localparam int unsigned STAT_W        = 2;
    localparam int unsigned IDX_W         = 10;
    localparam logic [CNT_W-1:0] PAGES_RESET = 11'd1024;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_FREE  = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_RD,
        S_CNT,
        S_RUN_RD,
        S_RUN,
        S_CMP_RD,
        S_CMP,
        S_CLR,
        S_FILL,
        S_OWN_RD,
        S_OWN,
        S_FREE_RD,
        S_FREE,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture request, clear scan pointers
        logic rd;         // issue table read at scan pointer
        logic count_step; // accumulate free count on read data
        logic run_step;   // advance run search on read data
        logic cmp_step;   // compaction move on read data
        logic clr_step;   // clear entry at write pointer
        logic fill_step;  // mark entry at fill pointer
        logic own_step;   // owner search on read data
        logic free_step;  // free run on read data
        logic rewind;     // reset scan pointers for a new pass
        logic set_comp;   // record compaction
        logic set_owner;  // lookup/free: owner found at the entry just read
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic    init_done;  // clearing pass after reset finished
        logic    scan_end;   // scan pointer reached managed count
        logic    cnt_bad;    // count zero, too large or too few free pages
        logic    run_hit;    // current read completes a run
        logic    own_hit;    // current read is owner
        logic    free_hit;   // current read continues the owner's run
        logic    clr_end;    // write pointer reached managed count
        logic    fill_end;   // run fully marked
        action_t act;
    } sts_t;

endpackage

// ===== rtl/cpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpa_ctrl: request sequencer
// Steps each request through count, search, compaction, fill, lookup, free.
// ----------------------------------------------------------------------------
module cpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           res_load,
    input  logic           res_busy,
    output cpa_pkg::cmd_t  cmd,
    input  cpa_pkg::sts_t  sts
);
    import cpa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        res_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = !res_busy && sts.init_done;
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CNT_RD;
                end
            end
            S_CNT_RD:
            begin
                if (sts.act != ACT_ALLOC)
                    state_next = S_OWN_RD;
                else if (sts.scan_end)
                    state_next = S_RUN_RD;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CNT;
                end
                if (sts.act == ACT_ALLOC && sts.scan_end)
                    cmd.rewind = 1'b1;
            end
            S_CNT:
            begin
                cmd.count_step = 1'b1;
                state_next     = S_CNT_RD;
            end
            S_RUN_RD:
            begin
                if (sts.cnt_bad)
                    state_next = S_DONE;
                else if (sts.scan_end)
                begin
                    cmd.rewind   = 1'b1;
                    cmd.set_comp = 1'b1;
                    state_next   = S_CMP_RD;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.run_step = 1'b1;
                state_next   = sts.run_hit ? S_FILL : S_RUN_RD;
            end
            S_CMP_RD:
            begin
                if (sts.scan_end)
                    state_next = S_CLR;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = S_CMP_RD;
            end
            S_CLR:
            begin
                if (sts.clr_end)
                    state_next = S_FILL;
                else
                    cmd.clr_step = 1'b1;
            end
            S_FILL:
            begin
                if (sts.fill_end)
                    state_next = S_DONE;
                else
                    cmd.fill_step = 1'b1;
            end
            S_OWN_RD:
            begin
                if (sts.scan_end)
                    state_next = S_DONE;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_OWN;
                end
            end
            S_OWN:
            begin
                cmd.own_step = 1'b1;
                if (sts.own_hit)
                begin
                    cmd.set_owner = 1'b1;
                    state_next    = (sts.act == ACT_FREE) ? S_FREE_RD : S_DONE;
                end
                else
                    state_next = S_OWN_RD;
            end
            S_FREE_RD:
            begin
                if (sts.scan_end)
                    state_next = S_DONE;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                cmd.free_step = 1'b1;
                state_next    = sts.free_hit ? S_FREE_RD : S_DONE;
            end
            S_DONE:
            begin
                res_load   = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/cpa_dp.sv =====
// ----------------------------------------------------------------------------
// cpa_dp: page table datapath
// Page table memory, scan and write pointers, counters and result register.
// ----------------------------------------------------------------------------
module cpa_dp #(
    parameter int unsigned MAX_PAGES = cpa_pkg::MAX_PAGES_DEF,
    parameter int unsigned PID_WIDTH = cpa_pkg::PID_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [cpa_pkg::ACT_W-1:0]    action,
    input  logic [cpa_pkg::PID_IN_W-1:0] pid,
    input  logic [cpa_pkg::CNT_W-1:0]    page_count,
    input  logic [cpa_pkg::PNUM_W-1:0]   page_number,
    input  logic [cpa_pkg::CNT_W-1:0]    pages_reg,
    input  cpa_pkg::cmd_t                cmd,
    output cpa_pkg::sts_t                sts,
    input  logic                         res_load,
    output logic                         res_busy,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cpa_pkg::STAT_W-1:0]   status,
    output logic [cpa_pkg::IDX_W-1:0]    page_index,
    output logic                         compacted
);
    import cpa_pkg::*;

    localparam int unsigned AW = $clog2(MAX_PAGES);
    localparam int unsigned PW = AW + 1;
    localparam int unsigned EW = PID_WIDTH + 1;
    localparam int unsigned WW = (PW > 17) ? PW : 17;

    // Entry: {used, owner}. Contents undefined until written; reset clears via
    // a clearing pass counted by init_reg.
    logic [EW-1:0] mem [MAX_PAGES];
    logic [EW-1:0] rdata_reg;

    action_t              act_reg;
    logic [PID_WIDTH-1:0] pid_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [PNUM_W-1:0]    pnum_reg;
    logic [PW-1:0]        n_reg;
    logic [PW-1:0]        scan_reg;
    logic [PW-1:0]        wp_reg;
    logic [PW-1:0]        free_reg;
    logic [PW-1:0]        run_reg;
    logic [PW-1:0]        first_reg;
    logic [PW-1:0]        fill_reg;
    logic                 comp_reg;
    logic                 found_reg;
    logic                 ok_reg;
    logic [PW-1:0]        init_reg;
    logic                 init_done_reg;

    logic                 out_valid_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [IDX_W-1:0]     index_reg;
    logic                 comp_out_reg;

    logic [PW-1:0]        n_sat;
    logic                 rd_used;
    logic                 rd_own;
    logic [PW-1:0]        scan_prev;
    logic [PW-1:0]        run_inc;
    logic [PW-1:0]        cnt_ext;
    logic [WW-1:0]        look_sum;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [EW-1:0]        wdata;

    assign n_sat     = (WW'(pages_reg) > WW'(MAX_PAGES)) ? PW'(MAX_PAGES)
                                                         : PW'(pages_reg);
    assign rd_used   = rdata_reg[EW-1];
    assign rd_own    = rd_used && (rdata_reg[PID_WIDTH-1:0] == pid_reg);
    assign scan_prev = scan_reg - PW'(1);
    assign run_inc   = run_reg + PW'(1);
    assign cnt_ext   = (WW'(cnt_reg) > WW'(MAX_PAGES)) ? '1 : PW'(cnt_reg);
    assign look_sum  = WW'(first_reg) + WW'(pnum_reg);

    assign sts.init_done = init_done_reg;
    assign sts.scan_end  = (scan_reg >= n_reg) || !init_done_reg;
    assign sts.cnt_bad   = (cnt_reg == '0) || (WW'(cnt_reg) > WW'(n_reg))
                           || (WW'(cnt_reg) > WW'(free_reg));
    assign sts.run_hit   = !rd_used && (run_inc == cnt_ext);
    assign sts.own_hit   = rd_own;
    assign sts.free_hit  = rd_own;
    assign sts.clr_end   = wp_reg >= n_reg;
    assign sts.fill_end  = fill_reg >= first_reg + cnt_ext;
    assign sts.act       = act_reg;

    // single write port
    always_comb
    begin
        we    = 1'b0;
        waddr = AW'(scan_prev);
        wdata = '0;
        if (!init_done_reg)
        begin
            we    = 1'b1;
            waddr = AW'(init_reg);
        end
        else if (cmd.cmp_step && rd_used)
        begin
            we    = 1'b1;
            waddr = AW'(wp_reg);
            wdata = rdata_reg;
        end
        else if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = AW'(wp_reg);
        end
        else if (cmd.fill_step)
        begin
            we    = 1'b1;
            waddr = AW'(fill_reg);
            wdata = {1'b1, pid_reg};
        end
        else if ((cmd.own_step && rd_own && act_reg == ACT_FREE) ||
                 (cmd.free_step && rd_own))
        begin
            we    = 1'b1;
            waddr = AW'(scan_prev);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (cmd.rd)
            rdata_reg <= mem[AW'(scan_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= '0;
            init_done_reg <= 1'b0;
        end
        else if (!init_done_reg)
        begin
            init_reg <= init_reg + PW'(1);
            if (init_reg == PW'(MAX_PAGES - 1))
                init_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action_t'(action);
            pid_reg   <= PID_WIDTH'(pid);
            cnt_reg   <= page_count;
            pnum_reg  <= page_number;
            n_reg     <= n_sat;
            scan_reg  <= '0;
            wp_reg    <= '0;
            free_reg  <= '0;
            run_reg   <= '0;
            comp_reg  <= 1'b0;
            found_reg <= 1'b0;
            ok_reg    <= 1'b0;
            first_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            if (cmd.rd)
                scan_reg <= scan_reg + PW'(1);
            if (cmd.rewind)
            begin
                scan_reg <= '0;
                run_reg  <= '0;
                wp_reg   <= '0;
            end
            if (cmd.set_comp)
                comp_reg <= 1'b1;
            if (cmd.count_step && !rd_used)
                free_reg <= free_reg + PW'(1);
            if (cmd.run_step)
            begin
                run_reg <= rd_used ? '0 : run_inc;
                if (sts.run_hit)
                begin
                    first_reg <= scan_reg - cnt_ext;
                    fill_reg  <= scan_reg - cnt_ext;
                    ok_reg    <= 1'b1;
                end
            end
            // after compaction the run begins just above the last moved entry
            if (cmd.cmp_step && rd_used)
            begin
                wp_reg    <= wp_reg + PW'(1);
                first_reg <= wp_reg + PW'(1);
                fill_reg  <= wp_reg + PW'(1);
            end
            if (cmd.clr_step)
                wp_reg <= wp_reg + PW'(1);
            if (cmd.set_comp)
                ok_reg <= 1'b1;
            if (cmd.fill_step)
                fill_reg <= fill_reg + PW'(1);
            if (cmd.set_owner)
            begin
                found_reg <= 1'b1;
                first_reg <= scan_prev;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg   <= ST_OK;
            index_reg    <= '0;
            comp_out_reg <= 1'b0;
            case (act_reg)
                ACT_ALLOC:
                begin
                    if (!ok_reg)
                        status_reg <= ST_NOSPACE;
                    else
                    begin
                        index_reg    <= IDX_W'(first_reg);
                        comp_out_reg <= comp_reg;
                    end
                end
                ACT_FREE:
                begin
                    if (found_reg)
                        index_reg <= IDX_W'(first_reg);
                end
                default:
                begin
                    if (!found_reg || look_sum >= WW'(n_reg))
                        status_reg <= ST_NOTFOUND;
                    else
                        index_reg <= IDX_W'(look_sum);
                end
            endcase
        end
    end

    assign res_busy   = out_valid_reg && !out_ready;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign page_index = index_reg;
    assign compacted  = comp_out_reg;

endmodule

// ===== rtl/contiguous_page_allocator_compacting.sv =====
// ----------------------------------------------------------------------------
// contiguous_page_allocator_compacting: first-fit page allocator, compacting
// Top level: config register, sequencer and page table datapath.
//
//   channel  | handshake              | payload
//   in       | in_valid / in_ready    | action, pid, page_count, page_number
//   out      | out_valid / out_ready  | status, page_index, compacted
//   cfg      | cfg_valid / cfg_ready  | cfg_data (pages_in_use)
//
// Each request runs in passes over the table: for allocate a count pass and a
// run search, then a fill of the run found, or a compaction pass, a clear sweep
// and a fill when no run fits; for read and write an owner search; for free an
// owner search and a free sweep. Each page is read through a registered table
// read.
// After reset a clearing pass over all MAX_PAGES entries runs before requests start.
// A waiting result blocks the next item only while out_ready is low.
// ----------------------------------------------------------------------------
module contiguous_page_allocator_compacting #(
    parameter int unsigned MAX_PAGES = cpa_pkg::MAX_PAGES_DEF,
    parameter int unsigned PID_WIDTH = cpa_pkg::PID_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cpa_pkg::ACT_W-1:0]    action,
    input  logic [cpa_pkg::PID_IN_W-1:0] pid,
    input  logic [cpa_pkg::CNT_W-1:0]    page_count,
    input  logic [cpa_pkg::PNUM_W-1:0]   page_number,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cpa_pkg::STAT_W-1:0]   status,
    output logic [cpa_pkg::IDX_W-1:0]    page_index,
    output logic                         compacted,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cpa_pkg::CNT_W-1:0]    cfg_data
);
    import cpa_pkg::*;

    logic [CNT_W-1:0] pages_reg;
    cmd_t             cmd;
    sts_t             sts;
    logic             res_load;
    logic             res_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pages_reg <= PAGES_RESET;
        else if (cfg_valid)
            pages_reg <= cfg_data;
    end

    cpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .res_load (res_load),
        .res_busy (res_busy),
        .cmd      (cmd),
        .sts      (sts)
    );

    cpa_dp #(
        .MAX_PAGES (MAX_PAGES),
        .PID_WIDTH (PID_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (action),
        .pid         (pid),
        .page_count  (page_count),
        .page_number (page_number),
        .pages_reg   (pages_reg),
        .cmd         (cmd),
        .sts         (sts),
        .res_load    (res_load),
        .res_busy    (res_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .page_index  (page_index),
        .compacted   (compacted)
    );

endmodule
